// ===== rtl/core/elgs_pkg.sv =====
`timescale 1ns / 1ps

package elgs_pkg;

   // Default sizing of the car bank
   localparam int DEF_MAX_CARS   = 4;
   localparam int DEF_MAX_FLOORS = 16;

   // Field widths on the channels
   localparam int REQ_TYPE_W = 2;
   localparam int FLOOR_IN_W = 4;
   localparam int CAR_IN_W   = 2;
   localparam int STATE_W    = 2;
   localparam int STOPS_W    = 5;
   localparam int CODE_W     = 2;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam int CARS_REG_W = 3;
   localparam int FLRS_REG_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_CARS_IN_USE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOORS_IN_USE = 1'd1;
   localparam logic [CARS_REG_W-1:0] CARS_RESET  = 3'd4;
   localparam logic [FLRS_REG_W-1:0] FLOORS_RESET = 5'd16;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_HALL  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_CABIN = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK  = 2'd2;

   // Report kinds
   localparam logic RK_ACK  = 1'b0;
   localparam logic RK_TICK = 1'b1;

   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [STATE_W-1:0] {
      MOT_IDLE = 2'd0,
      MOT_UP   = 2'd1,
      MOT_DOWN = 2'd2
   } motion_type;

   typedef enum logic [CODE_W-1:0] {
      RC_QUEUED    = 2'd0,
      RC_DOOR      = 2'd1,
      RC_BAD_FLOOR = 2'd2,
      RC_BAD_CAR   = 2'd3
   } code_type;

   typedef enum logic [1:0] {
      OP_HALL         = 2'd0,
      OP_CABIN        = 2'd1,
      OP_CABIN_NOFLR  = 2'd2,
      OP_REJECT       = 2'd3
   } op_type;

   // Decoded command; tick is carried as its own flag
   typedef struct packed {
      logic                  tick;
      op_type                op;
      logic [FLOOR_IN_W-1:0] floor;
      logic [CAR_IN_W-1:0]   car;
      code_type              code;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== rtl/core/elgs_if.sv =====
`timescale 1ns / 1ps

interface elgs_req_if import elgs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [FLOOR_IN_W-1:0] floor;
   logic [CAR_IN_W-1:0]   car;

   modport source (output valid, req_type, floor, car, input ready);
   modport sink   (input valid, req_type, floor, car, output ready);
endinterface

interface elgs_rsp_if import elgs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  report_kind;
   logic [CAR_IN_W-1:0]   car_index;
   logic [FLOOR_IN_W-1:0] car_floor;
   logic [STATE_W-1:0]    car_state;
   logic [STOPS_W-1:0]    stops_served;
   logic [CODE_W-1:0]     result_code;
   logic                  last;

   modport source (output valid, report_kind, car_index, car_floor, car_state,
                   stops_served, result_code, last, input ready);
   modport sink   (input valid, report_kind, car_index, car_floor, car_state,
                   stops_served, result_code, last, output ready);
endinterface

// ===== rtl/core/elgs_front.sv =====
`timescale 1ns / 1ps

module elgs_front import elgs_pkg::*; #(
   parameter int MAX_CARS   = DEF_MAX_CARS,
   parameter int MAX_FLOORS = DEF_MAX_FLOORS
) (
   elgs_req_if.sink                          req_chan,
   input  logic [$clog2(MAX_CARS+1)-1:0]     eff_cars,
   input  logic [$clog2(MAX_FLOORS+1)-1:0]   eff_floors,
   input  q_stat_type                        q_stat,
   output logic                              q_push,
   output cmd_type                           q_push_data
);

   logic known;
   logic floor_bad;
   logic car_bad;

   assign req_chan.ready = !q_stat.full;

   assign floor_bad = 32'(req_chan.floor) >= 32'(eff_floors);
   assign car_bad   = 32'(req_chan.car) >= 32'(eff_cars);

   // Classify the word and range-check it against the live counts
   always_comb begin
      known             = 1'b1;
      q_push_data.tick  = 1'b0;
      q_push_data.op    = OP_HALL;
      q_push_data.floor = req_chan.floor;
      q_push_data.car   = req_chan.car;
      q_push_data.code  = RC_QUEUED;
      unique case (req_chan.req_type)
         REQ_HALL: begin
            if (floor_bad) begin
               q_push_data.op   = OP_REJECT;
               q_push_data.car  = '0;
               q_push_data.code = RC_BAD_FLOOR;
            end
         end
         REQ_CABIN: begin
            if (car_bad) begin
               q_push_data.op   = OP_REJECT;
               q_push_data.code = RC_BAD_CAR;
            end else if (floor_bad) begin
               q_push_data.op = OP_CABIN_NOFLR;
            end else begin
               q_push_data.op = OP_CABIN;
            end
         end
         REQ_TICK: begin
            q_push_data.tick = 1'b1;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // Drop unknown request types: consume them without a queue entry
   assign q_push = req_chan.valid && req_chan.ready && known;

endmodule

// ===== rtl/core/elgs_queue.sv =====
`timescale 1ns / 1ps

module elgs_queue import elgs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_push,
   input  cmd_type    q_push_data,
   input  logic       q_pop,
   output cmd_type    q_head,
   output q_stat_type q_stat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign q_stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign q_head       = mem_ff[rd_ptr_ff];

   assign do_push = q_push && !q_stat.full;
   assign do_pop  = q_pop && !q_stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_push_data;
      end
   end

endmodule

// ===== rtl/core/elgs_back.sv =====
`timescale 1ns / 1ps

module elgs_back import elgs_pkg::*; #(
   parameter int MAX_CARS   = DEF_MAX_CARS,
   parameter int MAX_FLOORS = DEF_MAX_FLOORS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(MAX_CARS+1)-1:0]   eff_cars,
   input  q_stat_type                      q_stat,
   input  cmd_type                         q_head,
   output logic                            q_pop,
   elgs_rsp_if.source                      rsp_chan
);

   localparam int CAR_W    = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
   localparam int FLOOR_W  = $clog2(MAX_FLOORS);
   localparam int CNT_FL_W = $clog2(MAX_FLOORS + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_EXEC = 4'b0100,
      ST_TICK = 4'b1000
   } state_type;

   function automatic logic [CNT_FL_W-1:0] count_ones(input logic [MAX_FLOORS-1:0] v);
      logic [CNT_FL_W-1:0] n;
      n = '0;
      for (int i = 0; i < MAX_FLOORS; i++) begin
         n = n + CNT_FL_W'(v[i]);
      end
      return n;
   endfunction

   function automatic logic [FLOOR_W-1:0] top_bit(input logic [MAX_FLOORS-1:0] v);
      logic [FLOOR_W-1:0] k;
      k = '0;
      for (int i = 0; i < MAX_FLOORS; i++) begin
         if (v[i]) k = FLOOR_W'(i);
      end
      return k;
   endfunction

   function automatic logic [FLOOR_W-1:0] low_bit(input logic [MAX_FLOORS-1:0] v);
      logic [FLOOR_W-1:0] k;
      k = '0;
      for (int i = MAX_FLOORS - 1; i >= 0; i--) begin
         if (v[i]) k = FLOOR_W'(i);
      end
      return k;
   endfunction

   // Sequencer
   state_type state_ff, state_in;
   cmd_type   cmd_ff,   cmd_in;
   logic [CAR_W-1:0]   idx_ff,   idx_in;
   logic [CAR_W-1:0]   best_ff,  best_in;
   logic [FLOOR_W-1:0] bestd_ff, bestd_in;

   // Car bank
   logic [FLOOR_W-1:0]    floor_ff [MAX_CARS];
   logic [FLOOR_W-1:0]    floor_in [MAX_CARS];
   motion_type            motion_ff [MAX_CARS];
   motion_type            motion_in [MAX_CARS];
   logic [MAX_FLOORS-1:0] above_ff [MAX_CARS];
   logic [MAX_FLOORS-1:0] above_in [MAX_CARS];
   logic [MAX_FLOORS-1:0] below_ff [MAX_CARS];
   logic [MAX_FLOORS-1:0] below_in [MAX_CARS];

   // Output register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_kind_ff,  out_kind_in;
   logic [CAR_IN_W-1:0]   out_car_ff,   out_car_in;
   logic [FLOOR_IN_W-1:0] out_floor_ff, out_floor_in;
   logic [STATE_W-1:0]    out_state_ff, out_state_in;
   logic [STOPS_W-1:0]    out_stops_ff, out_stops_in;
   logic [CODE_W-1:0]     out_code_ff,  out_code_in;
   logic                  out_last_ff,  out_last_in;

   // Selected car, read at one index
   logic [FLOOR_W-1:0]    cur_floor;
   motion_type            cur_motion;
   logic [MAX_FLOORS-1:0] cur_above, cur_below;
   logic [FLOOR_W-1:0]    f;
   logic [FLOOR_W-1:0]    car_gap;
   logic                  take;
   logic [CAR_W-1:0]      scan_best;
   logic                  last_car;
   logic                  out_free;

   // Call filing
   logic [MAX_FLOORS-1:0] sub_above, sub_below;
   motion_type            sub_motion;
   code_type              sub_code;

   // Sweep
   logic [FLOOR_W-1:0]    sw_floor;
   motion_type            sw_motion;
   logic [MAX_FLOORS-1:0] sw_above, sw_below;
   logic [CNT_FL_W-1:0]   sw_stops;
   logic [FLOOR_W-1:0]    hi_bit, lo_bit;

   assign cur_floor  = floor_ff[idx_ff];
   assign cur_motion = motion_ff[idx_ff];
   assign cur_above  = above_ff[idx_ff];
   assign cur_below  = below_ff[idx_ff];
   assign f          = FLOOR_W'(cmd_ff.floor);

   assign car_gap   = (cur_floor > f) ? cur_floor - f : f - cur_floor;
   assign take      = (idx_ff == '0) || (car_gap < bestd_ff);
   assign scan_best = take ? idx_ff : best_ff;
   assign last_car  = 32'(idx_ff) == 32'(eff_cars) - 32'd1;
   assign out_free  = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      sub_above  = cur_above;
      sub_below  = cur_below;
      sub_motion = cur_motion;
      sub_code   = RC_QUEUED;
      if (f > cur_floor) begin
         sub_above = cur_above | (MAX_FLOORS'(1) << f);
         if (cur_motion == MOT_IDLE) sub_motion = MOT_UP;
      end else if (f < cur_floor) begin
         sub_below = cur_below | (MAX_FLOORS'(1) << f);
         if (cur_motion == MOT_IDLE) sub_motion = MOT_DOWN;
      end else begin
         sub_code = RC_DOOR;
      end
   end

   assign hi_bit = top_bit(cur_above);
   assign lo_bit = low_bit(cur_below);

   // LOOK sweep: run out every pending floor in the current direction
   always_comb begin
      sw_floor  = cur_floor;
      sw_motion = MOT_IDLE;
      sw_above  = cur_above;
      sw_below  = cur_below;
      sw_stops  = '0;
      case (cur_motion)
         MOT_UP: begin
            sw_stops  = count_ones(cur_above);
            if ((|cur_above) && (hi_bit > cur_floor)) sw_floor = hi_bit;
            sw_above  = '0;
            sw_motion = (|cur_below) ? MOT_DOWN : MOT_IDLE;
         end
         MOT_DOWN: begin
            sw_stops  = count_ones(cur_below);
            if ((|cur_below) && (lo_bit < cur_floor)) sw_floor = lo_bit;
            sw_below  = '0;
            sw_motion = (|cur_above) ? MOT_UP : MOT_IDLE;
         end
         default: begin
            sw_motion = MOT_IDLE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      best_in  = best_ff;
      bestd_in = bestd_ff;
      q_pop    = 1'b0;
      for (int c = 0; c < MAX_CARS; c++) begin
         floor_in[c]  = floor_ff[c];
         motion_in[c] = motion_ff[c];
         above_in[c]  = above_ff[c];
         below_in[c]  = below_ff[c];
      end
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_kind_in  = out_kind_ff;
      out_car_in   = out_car_ff;
      out_floor_in = out_floor_ff;
      out_state_in = out_state_ff;
      out_stops_in = out_stops_ff;
      out_code_in  = out_code_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               idx_in = '0;
               if (q_head.tick) begin
                  state_in = ST_TICK;
               end else begin
                  unique case (q_head.op) inside
                     OP_HALL: begin
                        state_in = ST_SCAN;
                     end
                     OP_CABIN, OP_CABIN_NOFLR: begin
                        idx_in   = CAR_W'(q_head.car);
                        state_in = ST_EXEC;
                     end
                     default: begin
                        state_in = ST_EXEC;
                     end
                  endcase
               end
            end
         end
         ST_SCAN: begin
            // Nearest car, one per cycle; strict compare keeps the lower index
            best_in  = scan_best;
            bestd_in = take ? car_gap : bestd_ff;
            if (last_car) begin
               idx_in   = scan_best;
               state_in = ST_EXEC;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = RK_ACK;
               out_stops_in = '0;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
               unique case (cmd_ff.op) inside
                  OP_REJECT: begin
                     out_car_in   = cmd_ff.car;
                     out_floor_in = '0;
                     out_state_in = MOT_IDLE;
                     out_code_in  = cmd_ff.code;
                  end
                  OP_CABIN_NOFLR: begin
                     out_car_in   = CAR_IN_W'(idx_ff);
                     out_floor_in = FLOOR_IN_W'(cur_floor);
                     out_state_in = cur_motion;
                     out_code_in  = RC_BAD_FLOOR;
                  end
                  default: begin
                     above_in[idx_ff]  = sub_above;
                     below_in[idx_ff]  = sub_below;
                     motion_in[idx_ff] = sub_motion;
                     out_car_in   = CAR_IN_W'(idx_ff);
                     out_floor_in = FLOOR_IN_W'(cur_floor);
                     out_state_in = sub_motion;
                     out_code_in  = sub_code;
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (out_free) begin
               floor_in[idx_ff]  = sw_floor;
               motion_in[idx_ff] = sw_motion;
               above_in[idx_ff]  = sw_above;
               below_in[idx_ff]  = sw_below;
               out_valid_in = 1'b1;
               out_kind_in  = RK_TICK;
               out_car_in   = CAR_IN_W'(idx_ff);
               out_floor_in = FLOOR_IN_W'(sw_floor);
               out_state_in = sw_motion;
               out_stops_in = STOPS_W'(sw_stops);
               out_code_in  = RC_QUEUED;
               out_last_in  = last_car;
               if (last_car) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int c = 0; c < MAX_CARS; c++) begin
            floor_ff[c]  <= '0;
            motion_ff[c] <= MOT_IDLE;
            above_ff[c]  <= '0;
            below_ff[c]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         for (int c = 0; c < MAX_CARS; c++) begin
            floor_ff[c]  <= floor_in[c];
            motion_ff[c] <= motion_in[c];
            above_ff[c]  <= above_in[c];
            below_ff[c]  <= below_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      bestd_ff     <= bestd_in;
      out_kind_ff  <= out_kind_in;
      out_car_ff   <= out_car_in;
      out_floor_ff <= out_floor_in;
      out_state_ff <= out_state_in;
      out_stops_ff <= out_stops_in;
      out_code_ff  <= out_code_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.report_kind  = out_kind_ff;
   assign rsp_chan.car_index    = out_car_ff;
   assign rsp_chan.car_floor    = out_floor_ff;
   assign rsp_chan.car_state    = out_state_ff;
   assign rsp_chan.stops_served = out_stops_ff;
   assign rsp_chan.result_code  = out_code_ff;
   assign rsp_chan.last         = out_last_ff;

endmodule

// ===== rtl/core/elevator_group_look_scheduler_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Word
// req_chan  in   valid/ready   req_type, floor, car
// rsp_chan  out  valid/ready   report_kind, car_index, car_floor, car_state,
//                              stops_served, result_code, last
// csr_*     in   csr_we        csr_index, csr_wdata (write only)
//
// Cabin and rejected calls go from queue head through ST_EXEC to the result word;
// hall calls pass ST_SCAN first, ticks use ST_TICK. The back end visits one car
// per cycle (ticks wait out rsp_chan stalls) via a single read port on the bank.
// The front end classifies a word in the cycle it is accepted and parks it in
// a two-entry queue, so req_chan keeps taking words while the back end works.
// A result word waits in the output register; a stall on rsp_chan holds the
// back end only. Reset is synchronous: all cars at floor 0, idle, no calls.

module elevator_group_look_scheduler_top import elgs_pkg::*; #(
   parameter int MAX_CARS   = DEF_MAX_CARS,
   parameter int MAX_FLOORS = DEF_MAX_FLOORS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   elgs_req_if.sink              req_chan,
   elgs_rsp_if.source            rsp_chan
);

   localparam int CAR_CNT_W = $clog2(MAX_CARS + 1);
   localparam int FL_CNT_W  = $clog2(MAX_FLOORS + 1);

   logic [CARS_REG_W-1:0] cars_ff;
   logic [FLRS_REG_W-1:0] floors_ff;
   logic [CAR_CNT_W-1:0]  eff_cars;
   logic [FL_CNT_W-1:0]   eff_floors;

   q_stat_type q_stat;
   logic       q_push;
   logic       q_pop;
   cmd_type    q_push_data;
   cmd_type    q_head;

   // Configuration registers: user writes only while block is quiet; not enforced
   always_ff @(posedge clock) begin
      if (reset) begin
         cars_ff   <= CARS_RESET;
         floors_ff <= FLOORS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CARS_IN_USE:   cars_ff   <= csr_wdata[CARS_REG_W-1:0];
            CSR_FLOORS_IN_USE: floors_ff <= csr_wdata[FLRS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the counts: zero acts as one, anything past the bank acts as full size
   always_comb begin
      if (cars_ff == '0) begin
         eff_cars = CAR_CNT_W'(1);
      end else if (32'(cars_ff) > MAX_CARS) begin
         eff_cars = CAR_CNT_W'(MAX_CARS);
      end else begin
         eff_cars = CAR_CNT_W'(cars_ff);
      end
      if (floors_ff == '0) begin
         eff_floors = FL_CNT_W'(1);
      end else if (32'(floors_ff) > MAX_FLOORS) begin
         eff_floors = FL_CNT_W'(MAX_FLOORS);
      end else begin
         eff_floors = FL_CNT_W'(floors_ff);
      end
   end

   elgs_front #(
      .MAX_CARS   (MAX_CARS),
      .MAX_FLOORS (MAX_FLOORS)
   ) u_front (
      .req_chan    (req_chan),
      .eff_cars    (eff_cars),
      .eff_floors  (eff_floors),
      .q_stat      (q_stat),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   elgs_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .q_push      (q_push),
      .q_push_data (q_push_data),
      .q_pop       (q_pop),
      .q_head      (q_head),
      .q_stat      (q_stat)
   );

   elgs_back #(
      .MAX_CARS   (MAX_CARS),
      .MAX_FLOORS (MAX_FLOORS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .eff_cars (eff_cars),
      .q_stat   (q_stat),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

   // Queue can never be full and empty together
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("command queue reports full and empty");

   // Tick reports always carry the queued code
   a_tick_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.report_kind == RK_TICK) |->
      (rsp_chan.result_code == RC_QUEUED))
      else $error("tick report with nonzero result code");

   // Acks never report served stops
   a_ack_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.report_kind == RK_ACK) |->
      (rsp_chan.stops_served == '0))
      else $error("ack with nonzero stop count");

   // Tick reports name only cars in use
   a_tick_car: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.report_kind == RK_TICK) |->
      (32'(rsp_chan.car_index) < 32'(eff_cars)))
      else $error("tick report for a car not in use");

endmodule

// ===== dv/elevator_group_look_scheduler_top_test.sv =====
`timescale 1ns / 1ps

module elevator_group_look_scheduler_top_test;
   import elgs_pkg::*;

   // Request type with no meaning to the block: it must be swallowed silently
   localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

   localparam int unsigned RESET_CYCLES = 12;
   localparam int unsigned MAX_WAIT     = 19;
   // Margin after the last owed word: two words may sit in the queue
   // behind the last result; allow plenty on top.
   localparam int unsigned DRAIN_CYCLES = 24;
   localparam int unsigned LONG_HOLD    = 250;
   localparam int unsigned LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] kind;
      logic [FLOOR_IN_W-1:0] floor;
      logic [CAR_IN_W-1:0]   car;
   } call_word_type;

   typedef struct packed {
      logic                  kind;
      logic [CAR_IN_W-1:0]   car;
      logic [FLOOR_IN_W-1:0] floor;
      logic [STATE_W-1:0]    state;
      logic [STOPS_W-1:0]    stops;
      logic [CODE_W-1:0]     code;
      logic                  last;
   } report_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   elgs_req_if req_if ();
   elgs_rsp_if rsp_if ();

   elevator_group_look_scheduler_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow of the car bank and the two registers
   // ---------------------------------------------------------------------
   logic [CARS_REG_W-1:0] shadow_cars_reg;
   logic [FLRS_REG_W-1:0] shadow_floors_reg;
   logic [FLOOR_IN_W-1:0] shadow_floor [DEF_MAX_CARS];
   motion_type            shadow_motion [DEF_MAX_CARS];
   logic [DEF_MAX_FLOORS-1:0] shadow_above [DEF_MAX_CARS];
   logic [DEF_MAX_FLOORS-1:0] shadow_below [DEF_MAX_CARS];

   // Report words still owed by the block, oldest first
   report_type due_reports[$];

   int unsigned errors = 0;
   int unsigned cycle_count = 0;
   bit          no_idle = 1'b0;     // both sides run flat out while set
   bit          hold_rsp_req = 1'b0; // ask the receiver for one long hold-off

   // Append one owed word behind the others
   function automatic void owe_report(report_type r);
      due_reports = {due_reports, r};
   endfunction

   // Register values of zero act as one; oversized values saturate
   function automatic int unsigned live_cars();
      int unsigned n;
      n = 32'(shadow_cars_reg);
      if (n == 0) n = 1;
      if (n > DEF_MAX_CARS) n = DEF_MAX_CARS;
      return n;
   endfunction

   function automatic int unsigned live_floors();
      int unsigned n;
      n = 32'(shadow_floors_reg);
      if (n == 0) n = 1;
      if (n > DEF_MAX_FLOORS) n = DEF_MAX_FLOORS;
      return n;
   endfunction

   // Log a call against one car; an idle car starts toward the call, a
   // moving car keeps its direction whatever side the call is on.
   function automatic code_type file_call(int unsigned c, logic [FLOOR_IN_W-1:0] f);
      if (f > shadow_floor[c]) begin
         shadow_above[c][f] = 1'b1;
         if (shadow_motion[c] == MOT_IDLE) shadow_motion[c] = MOT_UP;
         return RC_QUEUED;
      end
      if (f < shadow_floor[c]) begin
         shadow_below[c][f] = 1'b1;
         if (shadow_motion[c] == MOT_IDLE) shadow_motion[c] = MOT_DOWN;
         return RC_QUEUED;
      end
      return RC_DOOR;
   endfunction

   // Run one LOOK sweep for a car and return the stops it made. Every
   // pending bit on the active side counts, including ones above the
   // current floor count.
   function automatic logic [STOPS_W-1:0] sweep_car(int unsigned c);
      logic [STOPS_W-1:0]    stops;
      logic [FLOOR_IN_W-1:0] cur;
      stops = '0;
      cur   = shadow_floor[c];
      if (shadow_motion[c] == MOT_UP) begin
         for (int i = 0; i < DEF_MAX_FLOORS; i++) begin
            if (shadow_above[c][i]) begin
               if (i > cur) cur = FLOOR_IN_W'(i);
               stops++;
            end
         end
         shadow_above[c]  = '0;
         shadow_motion[c] = (shadow_below[c] != 0) ? MOT_DOWN : MOT_IDLE;
      end else if (shadow_motion[c] == MOT_DOWN) begin
         for (int i = DEF_MAX_FLOORS - 1; i >= 0; i--) begin
            if (shadow_below[c][i]) begin
               if (i < cur) cur = FLOOR_IN_W'(i);
               stops++;
            end
         end
         shadow_below[c]  = '0;
         shadow_motion[c] = (shadow_above[c] != 0) ? MOT_UP : MOT_IDLE;
      end else begin
         shadow_motion[c] = MOT_IDLE;
      end
      shadow_floor[c] = cur;
      return stops;
   endfunction

   // Advance the shadow by one accepted call word and queue what it owes
   function automatic void plan_reports(call_word_type w);
      report_type  r;
      int unsigned ncars, nfl, best, bestd, d;
      code_type    code;
      ncars = live_cars();
      nfl   = live_floors();
      r     = '0;
      r.kind = RK_ACK;
      r.last = 1'b1;
      case (w.kind)
         REQ_HALL: begin
            if (w.floor >= nfl) begin
               r.code = RC_BAD_FLOOR;
            end else begin
               // nearest car wins, ties to the lower index
               best  = 0;
               bestd = 32'hFFFF;
               for (int unsigned c = 0; c < ncars; c++) begin
                  d = (shadow_floor[c] > w.floor)
                      ? 32'(shadow_floor[c] - w.floor)
                      : 32'(w.floor - shadow_floor[c]);
                  if (d < bestd) begin
                     bestd = d;
                     best  = c;
                  end
               end
               code    = file_call(best, w.floor);
               r.car   = CAR_IN_W'(best);
               r.floor = shadow_floor[best];
               r.state = shadow_motion[best];
               r.code  = code;
            end
            owe_report(r);
         end
         REQ_CABIN: begin
            r.car = w.car;
            // car check comes before the floor check
            if (w.car >= ncars) begin
               r.code = RC_BAD_CAR;
            end else if (w.floor >= nfl) begin
               r.floor = shadow_floor[w.car];
               r.state = shadow_motion[w.car];
               r.code  = RC_BAD_FLOOR;
            end else begin
               code    = file_call(w.car, w.floor);
               r.floor = shadow_floor[w.car];
               r.state = shadow_motion[w.car];
               r.code  = code;
            end
            owe_report(r);
         end
         REQ_TICK: begin
            for (int unsigned c = 0; c < ncars; c++) begin
               r       = '0;
               r.kind  = RK_TICK;
               r.car   = CAR_IN_W'(c);
               r.stops = sweep_car(c);
               r.floor = shadow_floor[c];
               r.state = shadow_motion[c];
               r.code  = RC_QUEUED;
               r.last  = (c == ncars - 1);
               owe_report(r);
            end
         end
         default: ; // drop: unknown type owes nothing
      endcase
   endfunction

   function automatic string show(report_type r);
      return $sformatf("kind=%0d car=%0d floor=%0d state=%0d stops=%0d code=%0d last=%0d",
                       r.kind, r.car, r.floor, r.state, r.stops, r.code, r.last);
   endfunction

   function automatic int unsigned draw_wait();
      return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic call_word_type mk_word(logic [REQ_TYPE_W-1:0] kind,
                                             logic [FLOOR_IN_W-1:0] floor,
                                             logic [CAR_IN_W-1:0] car);
      call_word_type w;
      w.kind  = kind;
      w.floor = floor;
      w.car   = car;
      return w;
   endfunction

   // Mostly legal calls and ticks with random content; a tenth of floors
   // and cars are drawn from the whole field so rejects keep turning up.
   function automatic call_word_type random_word();
      call_word_type w;
      int unsigned   pick;
      pick = $urandom_range(0, 99);
      if (pick < 38)      w.kind = REQ_HALL;
      else if (pick < 76) w.kind = REQ_CABIN;
      else if (pick < 96) w.kind = REQ_TICK;
      else                w.kind = REQ_UNKNOWN;
      w.floor = ($urandom_range(0, 9) == 0) ? FLOOR_IN_W'($urandom_range(0, 15))
                                            : FLOOR_IN_W'($urandom_range(0, live_floors() - 1));
      w.car   = ($urandom_range(0, 9) == 0) ? CAR_IN_W'($urandom_range(0, 3))
                                            : CAR_IN_W'($urandom_range(0, live_cars() - 1));
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: offer one word and hold it until the block takes it. Valid is
   // left high on return so a back-to-back word reuses the same step.
   // ---------------------------------------------------------------------
   task automatic send_word(call_word_type w);
      int unsigned gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= w.kind;
      req_if.floor    <= w.floor;
      req_if.car      <= w.car;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      plan_reports(w);
   endtask

   // Drop valid, wait for every owed word, then let the back end go quiet
   task automatic settle();
      req_if.valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Callers settle first so the block is idle when a register changes
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CARS_IN_USE) shadow_cars_reg = data[CARS_REG_W-1:0];
      else                        shadow_floors_reg = data[FLRS_REG_W-1:0];
   endtask

   // ---------------------------------------------------------------------
   // Receiver and checker: compare each word taken on rsp against the
   // oldest owed report, then draw the stall before the next one.
   // ---------------------------------------------------------------------
   int unsigned stall_left = 0;

   always @(posedge clock) begin : rsp_sink
      report_type seen, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.kind  = rsp_if.report_kind;
            seen.car   = rsp_if.car_index;
            seen.floor = rsp_if.car_floor;
            seen.state = rsp_if.car_state;
            seen.stops = rsp_if.stops_served;
            seen.code  = rsp_if.result_code;
            seen.last  = rsp_if.last;
            if (due_reports.size() == 0) begin
               errors++;
               $display("%0t: unexpected word: expected none, actual %s", $time, show(seen));
            end else begin
               want = due_reports.pop_front();
               if (seen !== want) begin
                  errors++;
                  $display("%0t: word mismatch: expected %s, actual %s",
                           $time, show(want), show(seen));
               end
            end
            stall_left = draw_wait();
         end
         // long hold-off is counted here, the sender keeps pushing meanwhile
         if (hold_rsp_req) begin
            stall_left   = LONG_HOLD;
            hold_rsp_req = 1'b0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Guard against a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Fresh bank: every car idle at floor 0, a tick reports four zero-stop
   // cars and a call at floor 0 only cycles the door of car 0.
   task automatic test_reset_state();
      send_word(mk_word(REQ_TICK, 4'd0, 2'd0));
      send_word(mk_word(REQ_HALL, 4'd0, 2'd0));
      settle();
   endtask

   // Field extremes, tie breaks, calls against the motion, unknown type
   task automatic test_directed_calls();
      send_word(mk_word(REQ_HALL, 4'd15, 2'd3));   // all tied at 0: car 0 goes up
      send_word(mk_word(REQ_CABIN, 4'd15, 2'd3));  // top floor from the last car
      send_word(mk_word(REQ_CABIN, 4'd8, 2'd1));
      send_word(mk_word(REQ_CABIN, 4'd0, 2'd2));   // same floor: door only
      send_word(mk_word(REQ_HALL, 4'd3, 2'd2));    // car 0 again, already moving
      send_word(mk_word(REQ_TICK, 4'd15, 2'd3));   // sweep: several stops, cars idle
      send_word(mk_word(REQ_CABIN, 4'd2, 2'd0));   // car 0 at 15 heads down
      send_word(mk_word(REQ_CABIN, 4'd9, 2'd0));   // call below car 0, on its way down
      send_word(mk_word(REQ_HALL, 4'd7, 2'd0));    // nearest is car 1 at 8
      send_word(mk_word(REQ_HALL, 4'd11, 2'd1));   // car 1 again, above its motion
      send_word(mk_word(REQ_UNKNOWN, 4'd15, 2'd3));
      send_word(mk_word(REQ_TICK, 4'd0, 2'd0));    // down sweeps turn to pending up
      send_word(mk_word(REQ_TICK, 4'd0, 2'd0));
      send_word(mk_word(REQ_HALL, 4'd4, 2'd0));
      settle();
   endtask

   // Register extremes: single car and floor, zero acting as one, saturated
   // values, and a lowered floor count that still serves older calls.
   task automatic test_register_limits();
      write_csr(CSR_CARS_IN_USE, 5'd1);
      write_csr(CSR_FLOORS_IN_USE, 5'd1);
      send_word(mk_word(REQ_HALL, 4'd0, 2'd0));
      send_word(mk_word(REQ_HALL, 4'd1, 2'd0));    // floor out of range
      send_word(mk_word(REQ_CABIN, 4'd15, 2'd1));  // car out of range wins
      send_word(mk_word(REQ_CABIN, 4'd15, 2'd0));  // floor out of range on a good car
      send_word(mk_word(REQ_TICK, 4'd0, 2'd0));
      settle();
      write_csr(CSR_CARS_IN_USE, 5'd0);
      write_csr(CSR_FLOORS_IN_USE, 5'd0);
      send_word(mk_word(REQ_CABIN, 4'd0, 2'd0));
      send_word(mk_word(REQ_CABIN, 4'd0, 2'd3));
      send_word(mk_word(REQ_TICK, 4'd0, 2'd0));
      settle();
      write_csr(CSR_CARS_IN_USE, 5'd31);
      write_csr(CSR_FLOORS_IN_USE, 5'd31);
      send_word(mk_word(REQ_CABIN, 4'd12, 2'd3));
      send_word(mk_word(REQ_CABIN, 4'd14, 2'd2));
      settle();
      write_csr(CSR_FLOORS_IN_USE, 5'd4);
      send_word(mk_word(REQ_TICK, 4'd0, 2'd0));    // floors 12 and 14 still served
      send_word(mk_word(REQ_HALL, 4'd15, 2'd0));
      settle();
      write_csr(CSR_CARS_IN_USE, {2'b00, CARS_RESET});
      write_csr(CSR_FLOORS_IN_USE, FLOORS_RESET);
   endtask

   // Receiver holds off for a long stretch while the sender pushes without
   // gaps, so the queue fills and req ready must drop.
   task automatic test_backpressure();
      no_idle      = 1'b1;
      hold_rsp_req = 1'b1;
      for (int i = 0; i < 16; i++) send_word(random_word());
      settle();
      no_idle = 1'b0;
   endtask

   // Sender waits for every owed word before offering the next one
   task automatic test_drain_pause();
      for (int i = 0; i < 8; i++) begin
         send_word(random_word());
         settle();
      end
   endtask

   // Random traffic in phases, each under its own register setting
   task automatic test_random_traffic();
      for (int phase = 0; phase < 5; phase++) begin
         settle();
         write_csr(CSR_CARS_IN_USE, CSR_DATA_W'($urandom_range(0, 31)));
         write_csr(CSR_FLOORS_IN_USE, CSR_DATA_W'($urandom_range(0, 31)));
         no_idle = (phase == 2);
         for (int i = 0; i < 42; i++) send_word(random_word());
      end
      no_idle = 1'b0;
      settle();
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.req_type  = '0;
      req_if.floor     = '0;
      req_if.car       = '0;
      shadow_cars_reg   = CARS_RESET;
      shadow_floors_reg = FLOORS_RESET;
      for (int c = 0; c < DEF_MAX_CARS; c++) begin
         shadow_floor[c]  = '0;
         shadow_motion[c] = MOT_IDLE;
         shadow_above[c]  = '0;
         shadow_below[c]  = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_calls();
      test_register_limits();
      test_backpressure();
      test_drain_pause();
      test_random_traffic();

      settle();
      if (due_reports.size() != 0) begin
         errors++;
         $display("%0t: words never delivered: expected %0d, actual 0",
                  $time, due_reports.size());
      end
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
